/* rtl/core/uirb_pkg.sv */
// Shared types and codes for the UART interrupt ring buffers.
// No dependencies; imported by uirb_ring and the top module.
`default_nettype none

package uirb_pkg;

	// Item operation codes
	typedef enum logic [2:0] {
		OP_SERVICE = 3'd0,
		OP_PUT     = 3'd1,
		OP_GET     = 3'd2,
		OP_OPEN    = 3'd3,
		OP_CLOSE   = 3'd4
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_OPEN = 2'd1,
		ST_BUSY     = 2'd2,
		ST_BLOCK    = 2'd3
	} status_t;

	// Control sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// Commands to one ring pointer unit
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} ring_ctl_t;

	// Occupancy flags from one ring pointer unit
	typedef struct packed {
		logic empty;
		logic full;
		logic near_empty;   // at most one byte held
		logic near_full;    // at most one free slot
	} ring_sts_t;

endpackage

`default_nettype wire

/* rtl/core/uirb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for both byte rings.
`default_nettype none

module uirb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/uirb_ring.sv */
// Head and tail pointers of one ring, counting modulo twice the depth,
// with occupancy flags and memory indexes. Depends on uirb_pkg.
`default_nettype none

module uirb_ring #(
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire uirb_pkg::ring_ctl_t                      ctl,
	output uirb_pkg::ring_sts_t                           sts,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_idx,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_idx
);
	import uirb_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(2 * DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
	localparam logic [PW-1:0] PTR_HALF = PW'(DEPTH);
	localparam logic [PW:0]   SPAN     = (PW + 1)'(2 * DEPTH);
	localparam logic [PW:0]   FILL_MAX = (PW + 1)'(DEPTH);
	localparam logic [PW:0]   FILL_NF  = (PW + 1)'(DEPTH - 1);
	localparam logic [PW:0]   FILL_ONE = (PW + 1)'(1);

	logic [PW-1:0] head_q, tail_q;
	logic [PW-1:0] head_inc, tail_inc;
	logic [PW-1:0] head_off, tail_off;
	logic [PW:0]   fill;

	// Occupancy from the pointer distance
	always_comb begin
		if (tail_q >= head_q) begin
			fill = {1'b0, tail_q} - {1'b0, head_q};
		end else begin
			fill = {1'b0, tail_q} + SPAN - {1'b0, head_q};
		end
	end

	assign sts.empty      = (head_q == tail_q);
	assign sts.full       = (fill == FILL_MAX);
	assign sts.near_full  = (fill >= FILL_NF);
	assign sts.near_empty = (fill <= FILL_ONE);

	// Memory index is the pointer folded into the depth
	assign head_off = (head_q >= PTR_HALF) ? head_q - PTR_HALF : head_q;
	assign tail_off = (tail_q >= PTR_HALF) ? tail_q - PTR_HALF : tail_q;
	assign rd_idx   = head_off[IW-1:0];
	assign wr_idx   = tail_off[IW-1:0];

	// Wrapping increments
	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);

	// Pointer update; clear empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctl.clear) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= tail_inc;
			end
			if (ctl.pop) begin
				head_q <= head_inc;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/uart_interrupt_ring_buffers.sv */
// Interrupt-driven UART buffering: a receive ring and a transmit ring of RING_DEPTH bytes
// each, held in two synchronous RAMs, with the data-ready and THR-empty interrupt enables.
// Every item gives exactly one result. Accepting an item in the idle state updates
// pointers, enables and writes a pushed byte; the read state then waits for the registered
// RAM read of a popped byte before the result is loaded into the output register. The input
// is stalled throughout the read state, which lasts while the output register still holds
// an untaken result. No clearing pass follows reset: ring contents are only read after a
// push since the last open. Depends on uirb_pkg, uirb_ring, uirb_ram.
`default_nettype none

module uart_interrupt_ring_buffers #(
	parameter int RING_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] operation,
	input  wire logic       data_ready,
	input  wire logic       thr_empty,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] data_byte,
	// output channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [7:0]      read_byte,
	output logic            tx_valid,
	output logic [7:0]      tx_byte,
	output logic            rx_wake,
	output logic            tx_wake,
	output logic            rx_irq_enable,
	output logic            tx_irq_enable
);
	import uirb_pkg::*;

	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	state_t    state_q, state_nxt;
	logic      accept;
	logic      out_load;
	logic      out_free;

	logic      open_q, open_nxt;
	logic      rx_en_q, rx_en_nxt;
	logic      tx_en_q, tx_en_nxt;

	ring_ctl_t rx_ctl, tx_ctl;
	ring_sts_t rx_sts, tx_sts;
	logic [IW-1:0] rx_wr_idx, rx_rd_idx, tx_wr_idx, tx_rd_idx;
	logic [7:0]    rx_rdata, tx_rdata;
	logic [7:0]    rx_wdata, tx_wdata;

	status_t   st_nxt;
	logic      txv_nxt, rxw_nxt, txw_nxt, rd_nxt;

	// per-item results held over the RAM read cycle
	status_t   st_s1;
	logic      txv_s1, rxw_s1, txw_s1, rd_s1, rx_en_s1, tx_en_s1;

	// output register
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [7:0] read_byte_q, tx_byte_q;
	logic       tx_valid_q, rx_wake_q, tx_wake_q, rx_irq_enable_q, tx_irq_enable_q;

	// Ring pointers
	uirb_ring #(.DEPTH(RING_DEPTH)) u_rx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rx_ctl),
		.sts    (rx_sts),
		.wr_idx (rx_wr_idx),
		.rd_idx (rx_rd_idx)
	);

	uirb_ring #(.DEPTH(RING_DEPTH)) u_tx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tx_ctl),
		.sts    (tx_sts),
		.wr_idx (tx_wr_idx),
		.rd_idx (tx_rd_idx)
	);

	// Ring stores
	assign rx_wdata = rx_byte;
	assign tx_wdata = data_byte;

	uirb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_ctl.push),
		.waddr (rx_wr_idx),
		.wdata (rx_wdata),
		.re    (rx_ctl.pop),
		.raddr (rx_rd_idx),
		.rdata (rx_rdata)
	);

	uirb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_ctl.push),
		.waddr (tx_wr_idx),
		.wdata (tx_wdata),
		.re    (tx_ctl.pop),
		.raddr (tx_rd_idx),
		.rdata (tx_rdata)
	);

	// Sequencer: next state
	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_nxt = S_READ;
			S_READ:  if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			S_IDLE:  in_stall = 1'b0;
			S_READ:  out_load = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Item decode: ring commands, flags and status
	always_comb begin
		rx_ctl    = '0;
		tx_ctl    = '0;
		open_nxt  = open_q;
		rx_en_nxt = rx_en_q;
		tx_en_nxt = tx_en_q;
		st_nxt    = ST_OK;
		txv_nxt   = 1'b0;
		rxw_nxt   = 1'b0;
		txw_nxt   = 1'b0;
		rd_nxt    = 1'b0;
		if (accept) begin
			case (op_t'(operation))
				OP_SERVICE: begin
					if (!open_q) begin
						st_nxt = ST_NOT_OPEN;
					end else begin
						if (data_ready) begin
							rx_ctl.push = !rx_sts.full;
							rxw_nxt     = !rx_sts.full;
							if (rx_sts.near_full) rx_en_nxt = 1'b0;
						end
						if (thr_empty) begin
							tx_ctl.pop = !tx_sts.empty;
							txv_nxt    = !tx_sts.empty;
							txw_nxt    = !tx_sts.empty;
							if (tx_sts.near_empty) tx_en_nxt = 1'b0;
						end
					end
				end
				OP_PUT: begin
					if (!open_q) begin
						st_nxt = ST_NOT_OPEN;
					end else begin
						tx_en_nxt = 1'b1;
						if (tx_sts.full) st_nxt = ST_BLOCK;
						else tx_ctl.push = 1'b1;
					end
				end
				OP_GET: begin
					if (!open_q) begin
						st_nxt = ST_NOT_OPEN;
					end else begin
						rx_en_nxt = 1'b1;
						if (rx_sts.empty) begin
							st_nxt = ST_BLOCK;
						end else begin
							rx_ctl.pop = 1'b1;
							rd_nxt     = 1'b1;
						end
					end
				end
				OP_OPEN: begin
					if (open_q) begin
						st_nxt = ST_BUSY;
					end else begin
						rx_ctl.clear = 1'b1;
						tx_ctl.clear = 1'b1;
						open_nxt     = 1'b1;
						rx_en_nxt    = 1'b1;
					end
				end
				OP_CLOSE: begin
					if (!open_q) begin
						st_nxt = ST_NOT_OPEN;
					end else begin
						open_nxt  = 1'b0;
						rx_en_nxt = 1'b0;
						tx_en_nxt = 1'b0;
					end
				end
				default: st_nxt = ST_OK;
			endcase
		end
	end

	// Open flag and interrupt enables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			rx_en_q <= 1'b0;
			tx_en_q <= 1'b0;
		end else begin
			open_q  <= open_nxt;
			rx_en_q <= rx_en_nxt;
			tx_en_q <= tx_en_nxt;
		end
	end

	// Item results held while the RAM read completes
	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1    <= st_nxt;
			txv_s1   <= txv_nxt;
			rxw_s1   <= rxw_nxt;
			txw_s1   <= txw_nxt;
			rd_s1    <= rd_nxt;
			rx_en_s1 <= rx_en_nxt;
			tx_en_s1 <= tx_en_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q        <= st_s1;
			read_byte_q     <= rd_s1 ? rx_rdata : 8'd0;
			tx_valid_q      <= txv_s1;
			tx_byte_q       <= txv_s1 ? tx_rdata : 8'd0;
			rx_wake_q       <= rxw_s1;
			tx_wake_q       <= txw_s1;
			rx_irq_enable_q <= rx_en_s1;
			tx_irq_enable_q <= tx_en_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign read_byte     = read_byte_q;
	assign tx_valid      = tx_valid_q;
	assign tx_byte       = tx_byte_q;
	assign rx_wake       = rx_wake_q;
	assign tx_wake       = tx_wake_q;
	assign rx_irq_enable = rx_irq_enable_q;
	assign tx_irq_enable = tx_irq_enable_q;

endmodule

`default_nettype wire
